FILE: rtl/core/dfp_pkg.sv
`timescale 1ns / 1ps

package dfp_pkg;

    localparam int TFrac = 28;
    localparam int TWidth = TFrac + 1;
    localparam int NumCuts = 12;
    localparam logic [TWidth-1:0] TOne = TWidth'(1) << TFrac;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DOT,
        S_CUT,
        S_CUT_WAIT,
        S_SCAN,
        S_ENDPT,
        S_AXIS,
        S_DIV_SET,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [30:0] quot;
    } t_div_res;

    // Each breakpoint compares the magnitudes of two components, as a
    // difference or as a sum of the pair.
    function automatic logic [1:0] pair_first(input logic [3:0] idx);
        logic [1:0] r;
        unique case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: r = 2'd0;
            4'd6, 4'd7, 4'd8, 4'd9:             r = 2'd1;
            default:                            r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pair_second(input logic [3:0] idx);
        logic [1:0] r;
        unique case (idx)
            4'd0, 4'd3:                   r = 2'd1;
            4'd1, 4'd4, 4'd6, 4'd8:       r = 2'd2;
            default:                      r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic pair_is_sum(input logic [3:0] idx);
        logic r;
        unique case (idx)
            4'd3, 4'd4, 4'd5, 4'd8, 4'd9, 4'd11: r = 1'b1;
            default:                             r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

FILE: rtl/core/dual_edge_facet_projection_core.sv
`timescale 1ns / 1ps
// Projects the dual segment of a mesh edge onto the facets of the 4D hypercube.
// A request is taken when start is high and busy is low; its fields are the
// two-face flag and the two face planes (normal and offset, fixed point).
// A boundary edge request gives no result and busy stays low.
// For a shared edge busy rises for the whole computation, and 1 to 13 pieces
// come out in increasing order, each on the o_ ports for one cycle with
// o_valid high; o_last_piece marks the final one. The receiver cannot stall.
// One shared 31-step divider and one registered multiplier do all the work:
// the normal dot product, up to 12 breakpoint divisions, then per piece
// a scan of the breakpoints, the endpoint multiplies, the choice of axis
// and six divisions for the coordinates, then the output.
// Synchronous active-low reset returns the sequencer to idle.
module dual_edge_facet_projection_core #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_two_faces,
    input  logic signed [31:0] i_first_normal_x,
    input  logic signed [31:0] i_first_normal_y,
    input  logic signed [31:0] i_first_normal_z,
    input  logic signed [31:0] i_first_plane_offset,
    input  logic signed [31:0] i_second_normal_x,
    input  logic signed [31:0] i_second_normal_y,
    input  logic signed [31:0] i_second_normal_z,
    input  logic signed [31:0] i_second_plane_offset,
    output logic               o_valid,
    output logic [2:0]         o_facet,
    output logic               o_facing,
    output logic signed [31:0] o_start_u,
    output logic signed [31:0] o_start_v,
    output logic signed [31:0] o_start_s,
    output logic signed [31:0] o_end_u,
    output logic signed [31:0] o_end_v,
    output logic signed [31:0] o_end_s,
    output logic               o_last_piece
);
    import dfp_pkg::*;

    localparam logic [4:0] FracShift = 5'(COORD_FRAC_BITS);

    t_state r_state, n_state;

    logic signed [31:0] r_n1 [4];
    logic signed [31:0] r_n2 [4];
    logic signed [32:0] r_dn [4];
    logic [TFrac-1:0]   r_t  [NumCuts];
    logic signed [63:0] r_pa [4];
    logic signed [63:0] r_pb [4];
    logic signed [31:0] r_res [6];
    logic signed [66:0] r_acc;
    logic               r_facing;
    logic [3:0]         r_cnt;
    logic [TWidth-1:0]  r_tp1;
    logic [TWidth-1:0]  r_tp2;
    logic               r_found;
    logic [63:0]        r_best;
    logic [1:0]         r_ax;
    logic               r_pos;
    logic               r_neg;

    t_div_res           w_div;
    logic               w_div_start;
    logic [63:0]        w_div_num;
    logic [63:0]        w_div_den;
    logic [4:0]         w_div_shift;
    logic signed [32:0] w_mul_a;
    logic signed [32:0] w_mul_b;
    logic signed [65:0] w_prod;

    logic [1:0]         w_fa, w_fb;
    logic signed [33:0] w_num;
    logic signed [34:0] w_den;
    logic signed [34:0] w_aa;
    logic signed [34:0] w_dd;
    logic               w_cut_ok;
    logic signed [66:0] w_acc_sum;
    logic [3:0]         w_jm;
    logic signed [63:0] w_endpt;
    logic signed [63:0] w_mid;
    logic [63:0]        w_mid_mag;
    logic [1:0]         w_k;
    logic [1:0]         w_c;
    logic signed [63:0] w_cnum;
    logic [63:0]        w_cden;
    logic [TFrac-1:0]   w_tcur;
    logic signed [31:0] w_coord;

    dfp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_shift (w_div_shift),
        .o_res   (w_div)
    );

    dfp_multiplier u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_fa  = pair_first(r_cnt);
    assign w_fb  = pair_second(r_cnt);
    assign w_num = pair_is_sum(r_cnt) ? 34'(r_n1[w_fa]) + 34'(r_n1[w_fb])
                                      : 34'(r_n1[w_fa]) - 34'(r_n1[w_fb]);
    assign w_den = pair_is_sum(r_cnt) ? 35'(r_dn[w_fa]) + 35'(r_dn[w_fb])
                                      : 35'(r_dn[w_fa]) - 35'(r_dn[w_fb]);
    assign w_aa  = w_den[34] ? 35'(w_num) : -35'(w_num);
    assign w_dd  = w_den[34] ? -w_den : w_den;
    assign w_cut_ok = (w_den != 35'sd0) && (w_aa > 35'sd0) && (w_aa < w_dd);

    assign w_acc_sum = r_acc + 67'(w_prod);

    assign w_jm    = r_cnt - 4'd1;
    assign w_endpt = {{4{r_n1[w_jm[1:0]][31]}}, r_n1[w_jm[1:0]], {TFrac{1'b0}}}
                     + w_prod[63:0];

    assign w_mid     = r_pa[r_cnt[1:0]] + r_pb[r_cnt[1:0]];
    assign w_mid_mag = mag64(w_mid);

    assign w_k    = (r_cnt < 4'd3) ? r_cnt[1:0] : 2'(r_cnt - 4'd3);
    assign w_c    = r_ax + 2'd1 + w_k;
    assign w_cnum = (r_cnt < 4'd3) ? r_pa[w_c] : r_pb[w_c];
    always_comb begin
        w_cden = mag64((r_cnt < 4'd3) ? r_pa[r_ax] : r_pb[r_ax]);
        if (w_cden == 64'd0) begin
            w_cden = 64'd1;
        end
    end

    assign w_tcur = r_t[r_cnt];

    always_comb begin
        if (w_div.ovf) begin
            w_coord = r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_coord = r_neg ? -$signed({1'b0, w_div.quot}) : $signed({1'b0, w_div.quot});
        end
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_div_num   = {29'b0, w_aa};
        w_div_den   = {29'b0, w_dd};
        w_div_shift = 5'(TFrac);
        w_mul_a     = 33'(r_n1[r_cnt[1:0]]);
        w_mul_b     = 33'(r_n2[r_cnt[1:0]]);
        unique case (r_state)
            S_IDLE: begin
                if (start && i_two_faces) begin
                    n_state = S_DOT;
                end
            end
            S_DOT: begin
                if (r_cnt == 4'd3) begin
                    n_state = S_CUT;
                end
            end
            S_CUT: begin
                if (w_cut_ok) begin
                    w_div_start = 1'b1;
                    n_state     = S_CUT_WAIT;
                end else if (r_cnt == 4'(NumCuts - 1)) begin
                    n_state = S_SCAN;
                end
            end
            S_CUT_WAIT: begin
                if (w_div.done) begin
                    n_state = (r_cnt == 4'(NumCuts - 1)) ? S_SCAN : S_CUT;
                end
            end
            S_SCAN: begin
                if (r_cnt == 4'(NumCuts - 1)) begin
                    n_state = S_ENDPT;
                end
            end
            S_ENDPT: begin
                w_mul_a = $signed({4'b0, (r_cnt[2] ? r_tp2 : r_tp1)});
                w_mul_b = r_dn[r_cnt[1:0]];
                if (r_cnt == 4'd8) begin
                    n_state = S_AXIS;
                end
            end
            S_AXIS: begin
                if (r_cnt == 4'd3) begin
                    n_state = S_DIV_SET;
                end
            end
            S_DIV_SET: begin
                w_div_start = 1'b1;
                w_div_num   = mag64(w_cnum);
                w_div_den   = w_cden;
                w_div_shift = FracShift;
                n_state     = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                w_div_shift = FracShift;
                if (w_div.done) begin
                    n_state = (r_cnt == 4'd5) ? S_EMIT : S_DIV_SET;
                end
            end
            S_EMIT: begin
                n_state = r_found ? S_SCAN : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (n_state != r_state && !(r_state == S_CUT_WAIT && n_state == S_CUT)
                     && !(r_state == S_CUT && n_state == S_CUT_WAIT)
                     && !(r_state == S_DIV_WAIT && n_state == S_DIV_SET)
                     && !(r_state == S_DIV_SET && n_state == S_DIV_WAIT)) begin
            r_cnt <= '0;
        end else if (r_state == S_CUT_WAIT || r_state == S_DIV_WAIT) begin
            if (w_div.done) begin
                r_cnt <= r_cnt + 4'd1;
            end
        end else if (r_state == S_CUT) begin
            if (!w_cut_ok) begin
                r_cnt <= r_cnt + 4'd1;
            end
        end else if (r_state != S_IDLE && r_state != S_DIV_SET) begin
            r_cnt <= r_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_state == S_SCAN && r_state != S_SCAN) begin
            r_tp2   <= TOne;
            r_found <= 1'b0;
            if (r_state == S_EMIT) begin
                r_tp1 <= r_tp2;
            end
        end
        unique case (r_state)
            S_IDLE: begin
                r_n1[0] <= i_first_normal_x;
                r_n1[1] <= i_first_normal_y;
                r_n1[2] <= i_first_normal_z;
                r_n1[3] <= i_first_plane_offset;
                r_n2[0] <= i_second_normal_x;
                r_n2[1] <= i_second_normal_y;
                r_n2[2] <= i_second_normal_z;
                r_n2[3] <= i_second_plane_offset;
                r_dn[0] <= 33'(i_second_normal_x) - 33'(i_first_normal_x);
                r_dn[1] <= 33'(i_second_normal_y) - 33'(i_first_normal_y);
                r_dn[2] <= 33'(i_second_normal_z) - 33'(i_first_normal_z);
                r_dn[3] <= 33'(i_second_plane_offset) - 33'(i_first_plane_offset);
                r_acc   <= '0;
                r_tp1   <= '0;
            end
            S_DOT: begin
                if (r_cnt != 4'd0) begin
                    r_acc <= w_acc_sum;
                end
                if (r_cnt == 4'd3) begin
                    r_facing <= w_acc_sum > 67'sd0;
                end
            end
            S_CUT: begin
                if (!w_cut_ok) begin
                    r_t[r_cnt] <= '0;
                end
            end
            S_CUT_WAIT: begin
                if (w_div.done) begin
                    r_t[r_cnt] <= w_div.quot[TFrac-1:0];
                end
            end
            S_SCAN: begin
                if (TWidth'(w_tcur) > r_tp1 && TWidth'(w_tcur) < r_tp2) begin
                    r_tp2   <= TWidth'(w_tcur);
                    r_found <= 1'b1;
                end
            end
            S_ENDPT: begin
                if (r_cnt != 4'd0) begin
                    if (w_jm[2]) begin
                        r_pb[w_jm[1:0]] <= w_endpt;
                    end else begin
                        r_pa[w_jm[1:0]] <= w_endpt;
                    end
                end
            end
            S_AXIS: begin
                if (r_cnt == 4'd0 || w_mid_mag > r_best) begin
                    r_best <= w_mid_mag;
                    r_ax   <= r_cnt[1:0];
                    r_pos  <= w_mid > 64'sd0;
                end
            end
            S_DIV_SET: begin
                r_neg <= w_cnum[63];
            end
            S_DIV_WAIT: begin
                if (w_div.done) begin
                    r_res[r_cnt[2:0]] <= w_coord;
                end
            end
            S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    assign busy         = r_state != S_IDLE;
    assign o_valid      = r_state == S_EMIT;
    assign o_facet      = {~r_pos, r_ax};
    assign o_facing     = r_facing;
    assign o_start_u    = r_res[0];
    assign o_start_v    = r_res[1];
    assign o_start_s    = r_res[2];
    assign o_end_u      = r_res[3];
    assign o_end_v      = r_res[4];
    assign o_end_s      = r_res[5];
    assign o_last_piece = !r_found;

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a busy interval");

    a_more_pieces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_piece |=> busy)
        else $error("sequencer stopped before the last piece");

    a_boundary_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_two_faces |=> !busy)
        else $error("boundary edge started work");

    a_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_CUT_WAIT || r_state == S_DIV_WAIT))
        else $error("divider finished while nobody waited");

endmodule

FILE: rtl/core/dfp_divider.sv
`timescale 1ns / 1ps

module dfp_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [63:0]       i_num,
    input  logic [63:0]       i_den,
    input  logic [4:0]        i_shift,
    output dfp_pkg::t_div_res o_res
);
    import dfp_pkg::*;

    logic [95:0] w_dvd;
    logic [65:0] w_trial;
    logic [65:0] w_diff;
    logic        w_ge;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [64:0] r_rem;
    logic [30:0] r_low;
    logic [63:0] r_den;
    logic [30:0] r_quot;
    logic        r_ovf;

    assign w_dvd   = {32'b0, i_num} << i_shift;
    assign w_trial = {r_rem, r_low[30]};
    assign w_ge    = w_trial >= {2'b0, r_den};
    assign w_diff  = w_trial - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem  <= w_dvd[95:31];
            r_low  <= w_dvd[30:0];
            r_den  <= i_den;
            r_ovf  <= w_dvd[95:31] >= {1'b0, i_den};
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[64:0] : w_trial[64:0];
            r_low  <= {r_low[29:0], 1'b0};
            r_quot <= {r_quot[29:0], w_ge};
        end
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quot = r_quot;

endmodule

FILE: rtl/core/dfp_multiplier.sv
`timescale 1ns / 1ps

module dfp_multiplier (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_prod
);
    logic signed [65:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 66'(i_a) * 66'(i_b);
    end

    assign o_prod = r_prod;

endmodule
